### src/strm_pkg.sv
// Shared types, sizes and helper functions for the sparse table range minimum block.
package strm_pkg;

  localparam int unsigned DATA_WIDTH   = 32;
  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned LEVELS       = 11;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned LVL_W        = 4;
  localparam int unsigned ADDR_W       = LVL_W + IDX_W;
  localparam int unsigned DEPTH        = LEVELS * MAX_ELEMENTS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [LVL_W-1:0]             lvl_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Input request: one load or one query
  typedef struct packed {
    op_t                          op;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
    logic [IDX_W-1:0]             from_index;
    logic [IDX_W-1:0]             to_index;
  } in_req_t;

  // Result request: answer to one query
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] minimum;
    logic                         error;
  } out_rsp_t;

  // Table port controls from the sequencer to the memory
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  // Signed minimum of two entries
  function automatic data_t smin(input data_t a, input data_t b);
    return (a < b) ? a : b;
  endfunction

  // Table address of entry idx in level lvl
  function automatic addr_t tbl_addr(input lvl_t lvl, input idx_t idx);
    return {lvl, idx};
  endfunction

  // Position of the highest set bit of a range length
  function automatic lvl_t floor_log2(input cnt_t v);
    lvl_t r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

endpackage

### src/strm_table.sv
// Level table memory: one write port, two read ports with registered read data.
module strm_table (
  input  logic              clk,
  input  strm_pkg::mem_req_t mem_req,
  output strm_pkg::data_t   rd_a,
  output strm_pkg::data_t   rd_b
);

  strm_pkg::data_t mem [strm_pkg::DEPTH];
  strm_pkg::data_t rd_a_r;
  strm_pkg::data_t rd_b_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Read two entries, hold data between reads
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_a_r <= mem[mem_req.raddr_a];
      rd_b_r <= mem[mem_req.raddr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

### src/strm_seq.sv
// Sequencer: element loads, level-by-level table build, query lookups and result register.
module strm_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  strm_pkg::in_req_t  in_req,
  output logic               in_stall,
  output logic               out_valid,
  output strm_pkg::out_rsp_t out_rsp,
  input  logic               out_stall,
  output strm_pkg::mem_req_t mem_req,
  input  strm_pkg::data_t    rd_a,
  input  strm_pkg::data_t    rd_b
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_QUERY = 4'b0010,
    S_BUILD = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  strm_pkg::cnt_t     count_r, count_nxt;
  logic               built_r, built_nxt;
  strm_pkg::lvl_t     lvl_r, lvl_nxt;
  strm_pkg::idx_t     idx_r, idx_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  strm_pkg::addr_t    wr_addr_r, wr_addr_nxt;
  logic               q_err_r, q_err_nxt;
  logic               out_valid_r, out_valid_nxt;
  strm_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;

  logic                   accept;
  strm_pkg::cnt_t         cnt_base;
  strm_pkg::cnt_t         q_len;
  strm_pkg::lvl_t         q_lvl;
  strm_pkg::cnt_t         q_span;
  strm_pkg::cnt_t         q_idx_b;
  logic [strm_pkg::CNT_W:0] b_span;
  logic [strm_pkg::CNT_W:0] b_end;
  strm_pkg::cnt_t         b_half;
  strm_pkg::lvl_t         b_prev;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // Count as seen by a load: a finished build starts a new array
  assign cnt_base = built_r ? '0 : count_r;

  // Query level and second lookup index
  assign q_len   = {1'b0, in_req.to_index} - {1'b0, in_req.from_index} + strm_pkg::CNT_W'(1);
  assign q_lvl   = (strm_pkg::floor_log2(q_len) > strm_pkg::LVL_W'(strm_pkg::LEVELS - 1))
                   ? strm_pkg::LVL_W'(strm_pkg::LEVELS - 1) : strm_pkg::floor_log2(q_len);
  assign q_span  = strm_pkg::CNT_W'(1) << q_lvl;
  assign q_idx_b = {1'b0, in_req.to_index} + strm_pkg::CNT_W'(1) - q_span;

  // Build step geometry for the current level
  assign b_prev = lvl_r - strm_pkg::LVL_W'(1);
  assign b_half = strm_pkg::CNT_W'(1) << b_prev;
  assign b_span = (strm_pkg::CNT_W + 1)'(1) << lvl_r;
  assign b_end  = (strm_pkg::CNT_W + 1)'(idx_r) + (strm_pkg::CNT_W + 1)'(1) + b_span;

  // Next state, table port controls and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    built_nxt     = built_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    q_err_nxt     = q_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    mem_req       = '0;

    // Finish a pending build write from the last read pair
    if (wr_pend_r) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = wr_addr_r;
      mem_req.wdata = strm_pkg::smin(rd_a, rd_b);
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_req.op == strm_pkg::OP_LOAD)) begin
          built_nxt = 1'b0;
          count_nxt = cnt_base;
          if (cnt_base < strm_pkg::CNT_W'(strm_pkg::MAX_ELEMENTS)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = strm_pkg::tbl_addr('0, cnt_base[strm_pkg::IDX_W-1:0]);
            mem_req.wdata = in_req.value;
            count_nxt     = cnt_base + strm_pkg::CNT_W'(1);
          end
          if (in_req.last) begin
            if (count_nxt >= strm_pkg::CNT_W'(2)) begin
              lvl_nxt   = strm_pkg::LVL_W'(1);
              idx_nxt   = '0;
              state_nxt = S_BUILD;
            end else begin
              built_nxt = 1'b1;
            end
          end
        end else if (accept) begin
          q_err_nxt = !built_r || (in_req.from_index > in_req.to_index) ||
                      ({1'b0, in_req.to_index} >= count_r);
          mem_req.re      = 1'b1;
          mem_req.raddr_a = strm_pkg::tbl_addr(q_lvl, in_req.from_index);
          mem_req.raddr_b = strm_pkg::tbl_addr(q_lvl, q_idx_b[strm_pkg::IDX_W-1:0]);
          state_nxt       = S_QUERY;
        end
      end
      S_QUERY: begin
        // Hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (q_err_r) begin
            out_rsp_nxt.minimum = '0;
            out_rsp_nxt.error   = 1'b1;
          end else begin
            out_rsp_nxt.minimum = strm_pkg::smin(rd_a, rd_b);
            out_rsp_nxt.error   = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_BUILD: begin
        // Read the two halves, write their minimum next cycle
        mem_req.re      = 1'b1;
        mem_req.raddr_a = strm_pkg::tbl_addr(b_prev, idx_r);
        mem_req.raddr_b = strm_pkg::tbl_addr(b_prev,
                            idx_r + b_half[strm_pkg::IDX_W-1:0]);
        wr_pend_nxt     = 1'b1;
        wr_addr_nxt     = strm_pkg::tbl_addr(lvl_r, idx_r);
        if (b_end > {1'b0, count_r}) begin
          lvl_nxt   = lvl_r + strm_pkg::LVL_W'(1);
          idx_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + strm_pkg::IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // Last write of the level lands here; advance or finish
        if ((lvl_r < strm_pkg::LVL_W'(strm_pkg::LEVELS)) && (b_span <= {1'b0, count_r})) begin
          state_nxt = S_BUILD;
        end else begin
          built_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      built_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      built_r     <= built_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    q_err_r   <= q_err_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Loads write level 0 only; build writes never target level 0
  a_load_level0: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && !wr_pend_r) |->
      (mem_req.waddr[strm_pkg::ADDR_W-1:strm_pkg::IDX_W] == '0))
    else $error("load write outside level 0");

  a_build_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUILD) |->
      (lvl_r != '0) && (lvl_r < strm_pkg::LVL_W'(strm_pkg::LEVELS)))
    else $error("build level out of range");

  a_built_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> ($past(state_r) == S_DRAIN || $past(state_r) == S_IDLE))
    else $error("table marked built from wrong state");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= strm_pkg::CNT_W'(strm_pkg::MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_pend_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> ($past(state_r) == S_BUILD))
    else $error("build write without a preceding read");

endmodule

### src/sparse_table_range_minimum.sv
// Top level of the sparse table range minimum block.
// Loads and queries share one input channel. A load writes level 0 of the
// table. A query reads two table entries in the cycle it is taken and places
// its result in the output register from the query state, waiting while that
// register is still full; the input stalls meanwhile. A load marked last
// starts the build when at least two elements are loaded, which stalls the
// input: each level j with 2^j <= n for n loaded elements is filled in turn
// through the single write port of the table memory, then a drain state.
// No clearing pass is run after reset; a reversed query or one outside the
// entries written since the last load run returns an error and a zero minimum.
module sparse_table_range_minimum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  strm_pkg::in_req_t  in_req,
  output logic               in_stall,
  output logic               out_valid,
  output strm_pkg::out_rsp_t out_rsp,
  input  logic               out_stall
);

  strm_pkg::mem_req_t mem_req;
  strm_pkg::data_t    rd_a;
  strm_pkg::data_t    rd_b;

  // Sequencer for loads, build and queries
  strm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .out_stall (out_stall),
    .mem_req   (mem_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // Level table storage
  strm_table u_table (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

endmodule
